// File: src/hdf_pkg.sv
// Shared types, constants and character helpers for the hex dump formatter.
`timescale 1ns / 1ps

package hdf_pkg;

    // Default of the line buffer depth
    localparam int MAX_LINE_BYTES_DEF = 16;

    // Field widths fixed by the register map and the stream format
    localparam int ADDR_W    = 20;
    localparam int BPL_W     = 5;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int ADDR_DIGS = ADDR_W / 4;

    // Characters of the dump text
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    // Bounds of the non-printing ranges in the ASCII column
    localparam logic [7:0] PRINT_MIN = 8'd32;
    localparam logic [7:0] CTRL2_LO  = 8'h7F;
    localparam logic [7:0] CTRL2_HI  = 8'h9F;

    // Register indexes
    typedef enum logic {
        REG_BPL   = 1'b0,
        REG_START = 1'b1
    } t_hdf_reg;

    // Configuration handed from the register block to the sequencer
    typedef struct packed {
        logic [BPL_W-1:0]  bytes_per_line;
        logic [ADDR_W-1:0] start_offset;
    } t_hdf_cfg;

    // Sequencer phases, one output character per cycle outside idle while o_out does not stall
    typedef enum logic [3:0] {
        S_IDLE,
        S_ADDR,
        S_GAP1,
        S_HEX,
        S_PAD,
        S_GAP2,
        S_ASCII,
        S_CR,
        S_LF
    } t_hdf_state;

    // Uppercase hex digit of a nibble
    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) begin
            return 8'h30 + {4'b0, nib};
        end else begin
            return 8'h37 + {4'b0, nib};
        end
    endfunction

    // Byte as shown in the ASCII column
    function automatic logic [7:0] ascii_char(input logic [7:0] c);
        if (c < PRINT_MIN || (c >= CTRL2_LO && c <= CTRL2_HI)) begin
            return CH_DOT;
        end else begin
            return c;
        end
    endfunction

endpackage

// File: src/hdf_if.sv
// Stream interfaces for the byte input and the character output.
`timescale 1ns / 1ps

interface hdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hdf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       run_end;

    modport source (output valid, output out_char, output run_end, input ready);
    modport sink   (input valid, input out_char, input run_end, output ready);
endinterface

// File: src/hex_dump_formatter.sv
// Top level of the hex dump formatter: register block and character sequencer.
//
//  Channel   Dir  Handshake               Payload
//  i_in      in   valid / ready           data_byte[7:0], last_byte
//  o_out     out  valid / ready           out_char[7:0], run_end
//  APB       in   psel, penable, pready   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// The sequencer takes a byte only while idle and then emits its characters: for a
// line start the address digits and two spaces, for every byte two hex digits and
// a space, and when a line closes three spaces per missing byte, two spaces, the
// ASCII column of the bytes held and CR LF when the line is full.
// The character rate is set by the single output register, one character a cycle while o_out does not stall.
// Synchronous active-low reset clears the line position and the output valid flag.
// A stall on o_out holds the sequencer; the line buffer read is replayed in place.
`timescale 1ns / 1ps

module hex_dump_formatter #(
    parameter int MAX_LINE_BYTES = hdf_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [hdf_pkg::APB_AW-1:0] paddr,
    input  logic [hdf_pkg::APB_DW-1:0] pwdata,
    output logic [hdf_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    hdf_in_if.sink                     i_in,
    hdf_out_if.source                  o_out
);
    import hdf_pkg::*;

    t_hdf_cfg w_cfg;

    // Configuration registers
    hdf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Character sequencer with line buffer
    hdf_seq #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

// File: src/hdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/hdf_cfg.sv
// APB register block holding line length and start offset.
`timescale 1ns / 1ps

module hdf_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hdf_pkg::APB_AW-1:0]    paddr,
    input  logic [hdf_pkg::APB_DW-1:0]    pwdata,
    output logic [hdf_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    output hdf_pkg::t_hdf_cfg             o_cfg
);
    import hdf_pkg::*;

    logic [BPL_W-1:0]  r_bpl;
    logic [ADDR_W-1:0] r_start;
    logic              w_wr;
    t_hdf_reg          w_reg;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_reg  = t_hdf_reg'(paddr[2]);

    // Register writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpl   <= BPL_W'(MAX_LINE_BYTES_DEF);
            r_start <= '0;
        end else if (w_wr) begin
            unique case (w_reg)
                REG_BPL:   r_bpl   <= pwdata[BPL_W-1:0];
                REG_START: r_start <= pwdata[ADDR_W-1:0];
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (w_reg)
            REG_BPL:   prdata = {{(APB_DW-BPL_W){1'b0}}, r_bpl};
            REG_START: prdata = {{(APB_DW-ADDR_W){1'b0}}, r_start};
        endcase
    end

    assign o_cfg.bytes_per_line = r_bpl;
    assign o_cfg.start_offset   = r_start;

endmodule

// File: src/hdf_seq.sv
// Character sequencer: line buffer RAM, line state and output register.
`timescale 1ns / 1ps

module hdf_seq #(
    parameter int MAX_LINE_BYTES = hdf_pkg::MAX_LINE_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hdf_pkg::t_hdf_cfg i_cfg,
    hdf_in_if.sink            i_in,
    hdf_out_if.source         o_out
);
    import hdf_pkg::*;

    localparam int IDX_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int CNT_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int PAD_W = $clog2(3 * MAX_LINE_BYTES);
    localparam int CW    = (PAD_W > 3) ? PAD_W : 3;

    t_hdf_state        r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [ADDR_W-1:0] r_addr, n_addr;

    // Line state and the item being formatted
    logic [IDX_W-1:0]  r_bil;
    logic [ADDR_W-1:0] r_line_off;
    logic [7:0]        r_byte;
    logic [CNT_W-1:0]  r_count;
    logic              r_close;
    logic              r_full;
    logic [CW-1:0]     r_pad;

    // Output register
    logic              r_ov;
    logic [7:0]        r_oc;
    logic              r_oe;

    logic              w_accept;
    logic              w_adv;
    logic [CNT_W-1:0]  w_bpl;
    logic [CNT_W-1:0]  w_count;
    logic              w_full;
    logic              w_close;
    logic [CNT_W-1:0]  w_missing;
    logic [7:0]        w_rdata;
    logic [7:0]        c_char;
    logic              c_end;
    logic              c_emit;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_adv      = !r_ov || o_out.ready;

    // Clamp the line length and classify the incoming byte
    always_comb begin
        if (i_cfg.bytes_per_line == '0) begin
            w_bpl = CNT_W'(1);
        end else if (i_cfg.bytes_per_line > BPL_W'(MAX_LINE_BYTES)) begin
            w_bpl = CNT_W'(MAX_LINE_BYTES);
        end else begin
            w_bpl = i_cfg.bytes_per_line[CNT_W-1:0];
        end
    end

    assign w_count   = CNT_W'(r_bil) + CNT_W'(1);
    assign w_full    = (w_count >= w_bpl);
    assign w_close   = w_full || i_in.last_byte;
    assign w_missing = w_full ? '0 : (w_bpl - w_count);

    // Line buffer: byte written on accept, read back for the ASCII column
    hdf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_LINE_BYTES)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept),
        .i_waddr (r_bil),
        .i_wdata (i_in.data_byte),
        .i_raddr (n_cnt[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    // Next state and the character of this cycle
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_addr  = r_addr;
        c_char  = CH_SPACE;
        c_end   = 1'b0;
        c_emit  = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                c_emit = 1'b0;
                if (w_accept) begin
                    n_cnt   = '0;
                    n_addr  = r_line_off + i_cfg.start_offset;
                    n_state = (r_bil == '0) ? S_ADDR : S_HEX;
                end
            end
            S_ADDR: begin
                c_char = hex_char(r_addr[ADDR_W-1 -: 4]);
                if (w_adv) begin
                    n_addr = r_addr << 4;
                    if (r_cnt == CW'(ADDR_DIGS - 1)) begin
                        n_state = S_GAP1;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            S_GAP1: begin
                if (w_adv) begin
                    if (r_cnt == CW'(1)) begin
                        n_state = S_HEX;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            S_HEX: begin
                if (r_cnt == CW'(0)) begin
                    c_char = hex_char(r_byte[7:4]);
                end else if (r_cnt == CW'(1)) begin
                    c_char = hex_char(r_byte[3:0]);
                end else begin
                    c_char = CH_SPACE;
                    c_end  = !r_close;
                end
                if (w_adv) begin
                    if (r_cnt == CW'(2)) begin
                        if (!r_close) begin
                            n_state = S_IDLE;
                            n_cnt   = '0;
                        end else if (r_pad != '0) begin
                            n_state = S_PAD;
                            n_cnt   = r_pad - CW'(1);
                        end else begin
                            n_state = S_GAP2;
                            n_cnt   = '0;
                        end
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            S_PAD: begin
                if (w_adv) begin
                    if (r_cnt == '0) begin
                        n_state = S_GAP2;
                    end else begin
                        n_cnt = r_cnt - CW'(1);
                    end
                end
            end
            S_GAP2: begin
                if (w_adv) begin
                    if (r_cnt == CW'(1)) begin
                        n_state = S_ASCII;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            S_ASCII: begin
                c_char = ascii_char(w_rdata);
                c_end  = (r_cnt == CW'(r_count) - CW'(1)) && !r_full;
                if (w_adv) begin
                    if (r_cnt == CW'(r_count) - CW'(1)) begin
                        n_state = r_full ? S_CR : S_IDLE;
                        n_cnt   = '0;
                    end else begin
                        n_cnt = r_cnt + CW'(1);
                    end
                end
            end
            S_CR: begin
                c_char = CH_CR;
                if (w_adv) begin
                    n_state = S_LF;
                end
            end
            S_LF: begin
                c_char = CH_LF;
                c_end  = 1'b1;
                if (w_adv) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                c_emit  = 1'b0;
            end
        endcase
    end

    // Advance line state on accept
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bil      <= '0;
            r_line_off <= '0;
        end else if (w_accept) begin
            if (w_close) begin
                r_bil      <= '0;
                r_line_off <= i_in.last_byte ? '0 : (r_line_off + ADDR_W'(w_count));
            end else begin
                r_bil <= w_count[IDX_W-1:0];
            end
        end
    end

    // Hold the item being formatted
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_byte  <= i_in.data_byte;
            r_count <= w_count;
            r_close <= w_close;
            r_full  <= w_full;
            r_pad   <= (CW'(w_missing) << 1) + CW'(w_missing);
        end
    end

    // Output register: load when empty or taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= c_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && c_emit) begin
            r_oc <= c_char;
            r_oe <= c_end;
        end
    end

    assign o_out.valid    = r_ov;
    assign o_out.out_char = r_oc;
    assign o_out.run_end  = r_oe;

endmodule
